@@ hw/rtl/sll_pkg.sv @@
// sll_pkg: shared types and constants for the sample location lookup
// used by sll_front, sll_engine and sample_location_lookup
package sll_pkg;

	localparam int RUN_DEPTH   = 256;
	localparam int SIZE_DEPTH  = 4096;
	localparam int CHUNK_DEPTH = 1024;
	localparam int RUN_AW      = $clog2(RUN_DEPTH);
	localparam int SIZE_AW     = $clog2(SIZE_DEPTH);
	localparam int CHUNK_AW    = $clog2(CHUNK_DEPTH);
	localparam int CNT_W       = RUN_AW + 1;

	localparam logic [1:0] OP_LOAD_RUN   = 2'd0;
	localparam logic [1:0] OP_LOAD_SIZE  = 2'd1;
	localparam logic [1:0] OP_LOAD_CHUNK = 2'd2;
	localparam logic [1:0] OP_QUERY      = 2'd3;

	localparam logic [1:0] REG_DEFAULT_SIZE = 2'd0;
	localparam logic [1:0] REG_SAMPLE_COUNT = 2'd1;
	localparam logic [1:0] REG_RUN_COUNT    = 2'd2;
	localparam logic [1:0] REG_MDAT_BASE    = 2'd3;

	typedef struct packed {
		logic [31:0] default_sample_size;
		logic [31:0] sample_count;
		logic [8:0]  run_entry_count;
		logic [31:0] mdat_base_offset;
	} cfg_t;

	typedef struct packed {
		logic        is_query;
		logic        wr_run;
		logic        wr_size;
		logic        wr_chunk;
		logic [11:0] entry_index;
		logic [31:0] first_value;
		logic [31:0] chunk_run_length;
		logic [31:0] sample_number;
	} item_t;

	typedef struct packed {
		logic [31:0] chunk_number;
		logic [31:0] index_in_chunk;
		logic [31:0] offset_in_chunk;
		logic [31:0] chunk_offset;
		logic [31:0] sample_size;
		logic [31:0] mdat_offset;
		logic        lookup_error;
	} result_t;

endpackage

@@ hw/rtl/sll_front.sv @@
// sll_front: accepts input transactions, decodes the op and range checks loads
// holds a two-entry queue toward sll_engine; depends on sll_pkg
module sll_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           op,
	input  logic [11:0]          entry_index,
	input  logic [31:0]          first_value,
	input  logic [31:0]          chunk_run_length,
	input  logic [31:0]          sample_number,
	output logic                 q_valid,
	input  logic                 q_pop,
	output sll_pkg::item_t       q_item
);

	sll_pkg::item_t slot_q [2];
	logic [1:0] count_q;
	logic       rd_q;
	logic       wr_q;
	sll_pkg::item_t cls;
	logic       push;
	logic       pop;

	always_comb begin
		cls.is_query         = (op == sll_pkg::OP_QUERY);
		cls.wr_run           = (op == sll_pkg::OP_LOAD_RUN) &&
			({20'd0, entry_index} < 32'(sll_pkg::RUN_DEPTH));
		cls.wr_size          = (op == sll_pkg::OP_LOAD_SIZE) &&
			({20'd0, entry_index} < 32'(sll_pkg::SIZE_DEPTH));
		cls.wr_chunk         = (op == sll_pkg::OP_LOAD_CHUNK) &&
			({20'd0, entry_index} < 32'(sll_pkg::CHUNK_DEPTH));
		cls.entry_index      = entry_index;
		cls.first_value      = first_value;
		cls.chunk_run_length = chunk_run_length;
		cls.sample_number    = sample_number;
	end

	assign in_ready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = slot_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			rd_q    <= 1'b0;
			wr_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

@@ hw/rtl/sll_engine.sv @@
// sll_engine: table memories, run walk, divider, size sum and output register
// takes decoded items from sll_front; depends on sll_pkg
module sll_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sll_pkg::cfg_t        cfg,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  sll_pkg::item_t       q_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sll_pkg::result_t     out_res
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHECK, ST_RD_A, ST_CAP_A, ST_RD_B, ST_CAP_B, ST_CMP, ST_DIV,
		ST_CHUNK, ST_RD_C, ST_CAP_C, ST_MULD, ST_RD_S, ST_CAP_S, ST_SUM, ST_DONE
	} state_t;

	state_t state_q;

	logic [31:0] fc_mem   [sll_pkg::RUN_DEPTH];
	logic [31:0] spc_mem  [sll_pkg::RUN_DEPTH];
	logic [31:0] size_mem [sll_pkg::SIZE_DEPTH];
	logic [31:0] coff_mem [sll_pkg::CHUNK_DEPTH];

	logic [31:0] fc_rd_q, spc_rd_q, size_rd_q, coff_rd_q;
	logic [sll_pkg::RUN_AW-1:0]   run_ra;
	logic [sll_pkg::SIZE_AW-1:0]  size_ra;
	logic [sll_pkg::CHUNK_AW-1:0] coff_ra;

	logic [31:0] sm1_q, s_q, before_q, fc_q, spc_q, chunk_q, idx_q;
	logic [31:0] size_q, sum_q, coff_q, j_q;
	logic [sll_pkg::CNT_W-1:0] n_q, i_q;
	logic [63:0] prod_q;
	logic [31:0] rem_r_q, dq_q, div_q;
	logic [4:0]  dcnt_q;
	logic        pend_q, err_q;
	logic [31:0] rem;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [32:0] dstep;
	logic [32:0] ch;
	logic [sll_pkg::CNT_W:0] i_next;
	logic        pop;

	assign pop    = (state_q == ST_IDLE) && q_valid;
	assign q_pop  = pop;
	assign rem    = sm1_q - before_q;
	assign mul_p  = mul_a * mul_b;
	assign dstep  = {rem_r_q, dq_q[31]};
	assign ch     = {1'b0, fc_q} + {1'b0, dq_q};
	assign i_next = {1'b0, i_q} + 1'b1;

	always_comb begin
		run_ra = i_q[sll_pkg::RUN_AW-1:0];
		if (state_q == ST_RD_B) begin
			run_ra = i_next[sll_pkg::RUN_AW-1:0];
		end
		size_ra = sm1_q[sll_pkg::SIZE_AW-1:0];
		if (state_q == ST_SUM) begin
			size_ra = 12'(sm1_q - 32'd1 - j_q);
		end
		coff_ra = 10'(chunk_q - 32'd1);
		if (state_q == ST_CAP_B) begin
			mul_a = fc_rd_q - fc_q;
			mul_b = spc_q;
		end else begin
			mul_a = cfg.default_sample_size;
			mul_b = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_item.wr_run) begin
			fc_mem[q_item.entry_index[sll_pkg::RUN_AW-1:0]]  <= q_item.first_value;
			spc_mem[q_item.entry_index[sll_pkg::RUN_AW-1:0]] <= q_item.chunk_run_length;
		end
		fc_rd_q  <= fc_mem[run_ra];
		spc_rd_q <= spc_mem[run_ra];
	end

	always_ff @(posedge clk) begin
		if (pop && q_item.wr_size) begin
			size_mem[q_item.entry_index[sll_pkg::SIZE_AW-1:0]] <= q_item.first_value;
		end
		size_rd_q <= size_mem[size_ra];
	end

	always_ff @(posedge clk) begin
		if (pop && q_item.wr_chunk) begin
			coff_mem[q_item.entry_index[sll_pkg::CHUNK_AW-1:0]] <= q_item.first_value;
		end
		coff_rd_q <= coff_mem[coff_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			out_res   <= '0;
			err_q     <= 1'b0;
			pend_q    <= 1'b0;
			sm1_q     <= '0;
			s_q       <= '0;
			before_q  <= '0;
			fc_q      <= '0;
			spc_q     <= '0;
			chunk_q   <= '0;
			idx_q     <= '0;
			size_q    <= '0;
			sum_q     <= '0;
			coff_q    <= '0;
			j_q       <= '0;
			n_q       <= '0;
			i_q       <= '0;
			prod_q    <= '0;
			rem_r_q   <= '0;
			dq_q      <= '0;
			div_q     <= '0;
			dcnt_q    <= '0;
		end else begin
			if (out_valid && out_ready && state_q != ST_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop && q_item.is_query) begin
						s_q     <= q_item.sample_number;
						sm1_q   <= q_item.sample_number - 32'd1;
						err_q   <= 1'b0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					n_q      <= (cfg.run_entry_count > 9'(sll_pkg::RUN_DEPTH)) ?
						9'(sll_pkg::RUN_DEPTH) : cfg.run_entry_count;
					before_q <= '0;
					i_q      <= '0;
					if (s_q == 32'd0 || s_q > cfg.sample_count || cfg.run_entry_count == 9'd0) begin
						err_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RD_A;
					end
				end
				ST_RD_A: state_q <= ST_CAP_A;
				ST_CAP_A: begin
					fc_q  <= fc_rd_q;
					spc_q <= spc_rd_q;
					if (i_next < {1'b0, n_q}) begin
						state_q <= ST_RD_B;
					end else if (spc_rd_q == 32'd0) begin
						err_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						rem_r_q <= '0;
						dq_q    <= rem;
						div_q   <= spc_rd_q;
						dcnt_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_RD_B: state_q <= ST_CAP_B;
				ST_CAP_B: begin
					if (fc_rd_q <= fc_q) begin
						err_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						prod_q  <= mul_p;
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if ({32'd0, rem} >= prod_q) begin
						before_q <= before_q + prod_q[31:0];
						i_q      <= i_next[sll_pkg::CNT_W-1:0];
						state_q  <= ST_RD_A;
					end else begin
						rem_r_q <= '0;
						dq_q    <= rem;
						div_q   <= spc_q;
						dcnt_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (dstep >= {1'b0, div_q}) begin
						rem_r_q <= 32'(dstep - {1'b0, div_q});
						dq_q    <= {dq_q[30:0], 1'b1};
					end else begin
						rem_r_q <= dstep[31:0];
						dq_q    <= {dq_q[30:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd31) begin
						state_q <= ST_CHUNK;
					end
				end
				ST_CHUNK: begin
					idx_q <= rem_r_q;
					if (ch == 33'd0 || ch > 33'(sll_pkg::CHUNK_DEPTH)) begin
						err_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						chunk_q <= ch[31:0];
						state_q <= ST_RD_C;
					end
				end
				ST_RD_C: state_q <= ST_CAP_C;
				ST_CAP_C: begin
					coff_q <= coff_rd_q;
					if (cfg.default_sample_size != 32'd0) begin
						size_q  <= cfg.default_sample_size;
						prod_q  <= mul_p;
						state_q <= ST_MULD;
					end else if (s_q > 32'(sll_pkg::SIZE_DEPTH)) begin
						err_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RD_S;
					end
				end
				ST_MULD: begin
					sum_q   <= prod_q[31:0];
					state_q <= ST_DONE;
				end
				ST_RD_S: state_q <= ST_CAP_S;
				ST_CAP_S: begin
					size_q  <= size_rd_q;
					sum_q   <= '0;
					j_q     <= '0;
					pend_q  <= 1'b0;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (pend_q) begin
						sum_q <= sum_q + size_rd_q;
					end
					if (j_q < idx_q) begin
						j_q    <= j_q + 32'd1;
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						if (err_q) begin
							out_res <= '{lookup_error: 1'b1, default: '0};
						end else begin
							out_res.chunk_number    <= chunk_q;
							out_res.index_in_chunk  <= idx_q;
							out_res.offset_in_chunk <= sum_q;
							out_res.chunk_offset    <= coff_q;
							out_res.sample_size     <= size_q;
							out_res.mdat_offset     <= coff_q + sum_q - cfg.mdat_base_offset;
							out_res.lookup_error    <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_q != 32'd0))
		else $error("divide by zero in run walk");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (j_q <= idx_q))
		else $error("size sum ran past index");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_res.lookup_error) |-> (out_res.chunk_number == 32'd0 &&
		out_res.mdat_offset == 32'd0))
		else $error("error result carries data");

endmodule

@@ hw/rtl/sample_location_lookup.sv @@
// sample_location_lookup: top level, config registers, front queue and engine
// throughput: one item at a time in the engine; loads 1 per cycle while the engine is idle,
// queries bound by run walk, the 32-step divider and the size sum over one memory port
// reset: arst_n clears control and config registers; tables hold garbage until loaded
// depends on sll_pkg, sll_front, sll_engine
module sample_location_lookup (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// entry_index[11:0], first_value[43:12], chunk_run_length[75:44],
	// sample_number[107:76], zero fill
	input  logic [111:0]  s_axis_tdata,
	// op
	input  logic [1:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// chunk_number, index_in_chunk, offset_in_chunk, chunk_offset, sample_size,
	// mdat_offset, 32 bits each from bit 0
	output logic [191:0]  m_axis_tdata,
	// lookup_error
	output logic          m_axis_tuser,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	sll_pkg::cfg_t    cfg_q;
	sll_pkg::item_t   q_item;
	sll_pkg::result_t res;
	logic             q_valid;
	logic             q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				sll_pkg::REG_DEFAULT_SIZE: cfg_q.default_sample_size <= cfg_data;
				sll_pkg::REG_SAMPLE_COUNT: cfg_q.sample_count        <= cfg_data;
				sll_pkg::REG_RUN_COUNT:    cfg_q.run_entry_count     <= cfg_data[8:0];
				sll_pkg::REG_MDAT_BASE:    cfg_q.mdat_base_offset    <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	sll_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_axis_tvalid),
		.in_ready         (s_axis_tready),
		.op               (s_axis_tuser),
		.entry_index      (s_axis_tdata[11:0]),
		.first_value      (s_axis_tdata[43:12]),
		.chunk_run_length (s_axis_tdata[75:44]),
		.sample_number    (s_axis_tdata[107:76]),
		.q_valid          (q_valid),
		.q_pop            (q_pop),
		.q_item           (q_item)
	);

	sll_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {res.mdat_offset, res.sample_size, res.chunk_offset,
		res.offset_in_chunk, res.index_in_chunk, res.chunk_number};
	assign m_axis_tuser = res.lookup_error;

endmodule
